// ===== rtl/core/gtg_pkg.sv =====
// Shared types, constants and the arctangent table of the go-to-goal controller.
`default_nettype none
package gtg_pkg;

  localparam int unsigned SqrtBits = 17;
  localparam int unsigned RemWidth = 35;
  localparam int unsigned CordicW  = 28;
  localparam int unsigned AngleW   = 34;
  localparam int unsigned TabBits  = 5;

  localparam logic signed [AngleW-1:0] PiQ30   = 34'sd3373259426;
  localparam logic signed [16:0]       PiQ12   = 17'sd12868;
  localparam logic signed [16:0]       TwoPiQ12 = 17'sd25736;

  typedef enum logic [1:0] {
    MODE_ARRIVED = 2'd0,
    MODE_TURN    = 2'd1,
    MODE_DRIVE   = 2'd2
  } drive_mode_e;

  typedef enum logic [2:0] {
    REG_TARGET_X  = 3'd0,
    REG_TARGET_Y  = 3'd1,
    REG_GAIN_LIN  = 3'd2,
    REG_GAIN_ANG  = 3'd3,
    REG_SPEED_LIM = 3'd4,
    REG_ARRIVE_R  = 3'd5,
    REG_HEAD_TOL  = 3'd6,
    REG_UNUSED    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [14:0] heading;
  } sq_side_t;

  typedef struct packed {
    logic [SqrtBits-1:0] reach;
    logic signed [14:0]  heading;
  } cd_side_t;

  function automatic logic signed [AngleW-1:0] atan_q30(input logic [TabBits-1:0] idx);
    logic signed [AngleW-1:0] r;
    unique case (idx)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gtg_if.sv =====
// Valid/ready channels carrying robot poses and drive commands.
`default_nettype none
interface gtg_pose_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [14:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_cmd_if;
  logic               valid;
  logic               ready;
  logic [15:0]        linear_speed;
  logic signed [15:0] angular_rate;
  logic [1:0]         drive_mode;
  modport source (output valid, linear_speed, angular_rate, drive_mode, input ready);
  modport sink   (input valid, linear_speed, angular_rate, drive_mode, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gtg_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module gtg_sqrt (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 ready_o,
  input  wire logic [gtg_pkg::RemWidth-1:0]    value_i,
  input  wire gtg_pkg::sq_side_t               side_i,
  output logic                                 valid_o,
  input  wire logic                            ready_i,
  output logic [gtg_pkg::SqrtBits-1:0]         root_o,
  output gtg_pkg::sq_side_t                    side_o
);
  import gtg_pkg::*;

  localparam int unsigned N = SqrtBits;

  logic [RemWidth-1:0] rem_q  [N];
  logic [SqrtBits-1:0] root_q [N];
  sq_side_t            side_q [N];
  logic [N-1:0]        v_q;
  logic [N:0]          en;

  always_comb begin
    en[N] = ready_i;
    for (int j = N - 1; j >= 0; j--) begin
      en[j] = !v_q[j] || en[j+1];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int unsigned B = N - 1 - j;
    logic [RemWidth-1:0] rem_in, trial, rem_d;
    logic [SqrtBits-1:0] root_in, root_d;
    sq_side_t            side_in;
    logic                v_in;

    if (j == 0) begin : g_first
      assign rem_in  = value_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
      assign v_in    = v_q[j-1];
    end

    always_comb begin
      trial = (RemWidth'(root_in) << (B + 1)) | (RemWidth'(1) << (2 * B));
      rem_d  = rem_in;
      root_d = root_in;
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (SqrtBits'(1) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule
`default_nettype wire

// ===== rtl/core/gtg_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2 in Q3.12 radians.
`default_nettype none
module gtg_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic signed [16:0] dx_i,
  input  wire logic signed [16:0] dy_i,
  input  wire gtg_pkg::cd_side_t  side_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic signed [15:0]      angle_o,
  output gtg_pkg::cd_side_t       side_o
);
  import gtg_pkg::*;

  logic signed [CordicW-1:0] x_q [STEPS+1];
  logic signed [CordicW-1:0] y_q [STEPS+1];
  logic signed [AngleW-1:0]  z_q [STEPS+1];
  cd_side_t                  side_q [STEPS+1];
  logic [STEPS:0]            v_q;
  logic [STEPS+1:0]          en;

  logic signed [CordicW-1:0] x0, y0;
  logic signed [AngleW-1:0]  zr;

  always_comb begin
    en[STEPS+1] = ready_i;
    for (int j = STEPS; j >= 0; j--) begin
      en[j] = !v_q[j] || en[j+1];
    end
  end

  assign x0 = $signed({{3{dx_i[16]}}, dx_i, 8'b0});
  assign y0 = $signed({{3{dy_i[16]}}, dy_i, 8'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_i;
      if (x0 < 0) begin
        x_q[0] <= -x0;
        y_q[0] <= -y0;
        z_q[0] <= (y0 >= 0) ? PiQ30 : -PiQ30;
      end else begin
        x_q[0] <= x0;
        y_q[0] <= y0;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CordicW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en[i+1]) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i+1]) begin
        side_q[i+1] <= side_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + atan_q30(TabBits'(i));
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - atan_q30(TabBits'(i));
        end
      end
    end
  end

  assign zr      = z_q[STEPS] + AngleW'(131072);
  assign angle_o = zr[AngleW-1:18];
  assign ready_o = en[0];
  assign valid_o = v_q[STEPS];
  assign side_o  = side_q[STEPS];

endmodule
`default_nettype wire

// ===== rtl/core/go_to_goal_steering_controller.sv =====
// Top level of the go-to-goal steering controller.
//
// Poses arrive as beats on pose_ch (pos_x, pos_y in Q7.8, heading in Q2.12)
// and one drive command per pose leaves on cmd_ch, in order. The target,
// gains, speed limit, arrival radius and heading tolerance are to be written
// through cfg_we_i/cfg_index_i/cfg_data_i only while the block is idle; the
// block itself does not enforce this. A pose passes the difference, square
// and sum registers, 17 square-root stages, one quadrant stage plus
// CORDIC_STEPS arctangent stages, and the error wrap, gain multiply and
// clamp registers. One pose is accepted every cycle while nothing is stalled.
// Each stage holds its beat while the one after it is full and stalled, so
// a stalled receiver backs up the pipeline stage by stage and pose_ch.ready
// drops only once every stage holds a beat. Reset empties the pipeline and
// loads the register defaults (target 1.0,1.0; gains 1.0; speed limit 3.0;
// radius 0.1; tolerance 0.2 rad).
`default_nettype none
module go_to_goal_steering_controller #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  gtg_pose_if.sink         pose_ch,
  gtg_cmd_if.source        cmd_ch
);
  import gtg_pkg::*;

  logic signed [15:0] tx_q, ty_q;
  logic [11:0]        gl_q, ga_q;
  logic [15:0]        lim_q;
  logic [14:0]        rad_q;
  logic [13:0]        tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q  <= 16'sd256;
      ty_q  <= 16'sd256;
      gl_q  <= 12'd256;
      ga_q  <= 12'd256;
      lim_q <= 16'd768;
      rad_q <= 15'd26;
      tol_q <= 14'd819;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TARGET_X:  tx_q  <= cfg_data_i;
        REG_TARGET_Y:  ty_q  <= cfg_data_i;
        REG_GAIN_LIN:  gl_q  <= cfg_data_i[11:0];
        REG_GAIN_ANG:  ga_q  <= cfg_data_i[11:0];
        REG_SPEED_LIM: lim_q <= cfg_data_i;
        REG_ARRIVE_R:  rad_q <= cfg_data_i[14:0];
        REG_HEAD_TOL:  tol_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // front stages: difference, squares, sum
  logic               v1_q, v2_q, v3_q, en1, en2, en3;
  sq_side_t           s1_q, s2_q, s3_q;
  logic [33:0]        sqx_q, sqy_q;
  logic [RemWidth-1:0] sum_q;
  logic               sq_ready;

  assign en1 = !v1_q || en2;
  assign en2 = !v2_q || en3;
  assign en3 = !v3_q || sq_ready;
  assign pose_ch.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pose_ch.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q.dx      <= 17'(tx_q) - 17'(pose_ch.pos_x);
      s1_q.dy      <= 17'(ty_q) - 17'(pose_ch.pos_y);
      s1_q.heading <= pose_ch.heading;
    end
    if (en2) begin
      s2_q  <= s1_q;
      sqx_q <= 34'(s1_q.dx * s1_q.dx);
      sqy_q <= 34'(s1_q.dy * s1_q.dy);
    end
    if (en3) begin
      s3_q  <= s2_q;
      sum_q <= RemWidth'(sqx_q) + RemWidth'(sqy_q);
    end
  end

  logic                sq_valid, cd_ready;
  logic [SqrtBits-1:0] sq_root;
  sq_side_t            sq_side;
  cd_side_t            cd_in_side, cd_side;
  logic                cd_valid;
  logic signed [15:0]  cd_angle;
  logic                enA, enB, enC;

  gtg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .ready_o (sq_ready),
    .value_i (sum_q),
    .side_i  (s3_q),
    .valid_o (sq_valid),
    .ready_i (cd_ready),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign cd_in_side.reach   = sq_root;
  assign cd_in_side.heading = sq_side.heading;

  gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (cd_ready),
    .dx_i    (sq_side.dx),
    .dy_i    (sq_side.dy),
    .side_i  (cd_in_side),
    .valid_o (cd_valid),
    .ready_i (enA),
    .angle_o (cd_angle),
    .side_o  (cd_side)
  );

  // back stages: wrap and decide, multiply, clamp
  logic               vA_q, vB_q, vC_q;
  logic signed [16:0] err_raw, err_d, err_q;
  logic [16:0]        mag;
  logic [SqrtBits-1:0] distA_q;
  drive_mode_e        modeA_q, modeB_q, modeA_d;
  logic signed [28:0] pa_q;
  logic [28:0]        pl_q;
  logic signed [16:0] ang_sh;
  logic [20:0]        lin_sh;
  logic [15:0]        lin_q;
  logic signed [15:0] ang_q;
  drive_mode_e        modeC_q;

  assign enA = !vA_q || enB;
  assign enB = !vB_q || enC;
  assign enC = !vC_q || cmd_ch.ready;

  assign err_raw = 17'(cd_angle) - 17'(cd_side.heading);
  always_comb begin
    err_d = err_raw;
    if (err_raw > PiQ12) begin
      err_d = err_raw - TwoPiQ12;
    end else if (err_raw < -PiQ12) begin
      err_d = err_raw + TwoPiQ12;
    end
    mag = err_d[16] ? 17'(-err_d) : 17'(err_d);
    priority if (cd_side.reach <= {2'b0, rad_q}) begin
      modeA_d = MODE_ARRIVED;
    end else if (mag > {3'b0, tol_q}) begin
      modeA_d = MODE_TURN;
    end else begin
      modeA_d = MODE_DRIVE;
    end
  end

  assign ang_sh = 17'(pa_q >>> 12);
  assign lin_sh = pl_q[28:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
      vB_q <= 1'b0;
      vC_q <= 1'b0;
    end else begin
      if (enA) vA_q <= cd_valid;
      if (enB) vB_q <= vA_q;
      if (enC) vC_q <= vB_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enA) begin
      err_q   <= err_d;
      distA_q <= cd_side.reach;
      modeA_q <= modeA_d;
    end
    if (enB) begin
      pa_q    <= 29'($signed({1'b0, ga_q}) * err_q);
      pl_q    <= 29'(gl_q * distA_q);
      modeB_q <= modeA_q;
    end
    if (enC) begin
      modeC_q <= modeB_q;
      unique case (modeB_q)
        MODE_TURN: begin
          lin_q <= '0;
          if (ang_sh > 17'sd32767) begin
            ang_q <= 16'sd32767;
          end else if (ang_sh < -17'sd32768) begin
            ang_q <= -16'sd32768;
          end else begin
            ang_q <= ang_sh[15:0];
          end
        end
        MODE_DRIVE: begin
          ang_q <= '0;
          lin_q <= (lin_sh > 21'(lim_q)) ? lim_q : lin_sh[15:0];
        end
        default: begin
          lin_q <= '0;
          ang_q <= '0;
        end
      endcase
    end
  end

  assign cmd_ch.valid        = vC_q;
  assign cmd_ch.linear_speed = lin_q;
  assign cmd_ch.angular_rate = ang_q;
  assign cmd_ch.drive_mode   = modeC_q;

endmodule
`default_nettype wire

// ===== tb/gtg_checker.sv =====
// Checker that predicts drive commands from accepted poses and compares them on the command channel.
`default_nettype none
module gtg_checker
  import gtg_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  gtg_pose_if              pose_ch,
  gtg_cmd_if               cmd_ch,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]        linear_speed;
    logic signed [15:0] angular_rate;
    drive_mode_e        drive_mode;
  } cmd_t;

  cmd_t cmd_q[$];

  logic signed [15:0] tgt_x, tgt_y;
  logic [11:0] k_lin, k_ang;
  logic [15:0] v_max;
  logic [14:0] r_arr;
  logic [13:0] tol;

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint bearing_q12(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PiQ30) : -longint'(PiQ30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_q30(TabBits'(i)));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_q30(TabBits'(i)));
      end
    end
    return floor_shift(z + (64'sd1 <<< 17), 18);
  endfunction

  function automatic cmd_t steer(logic signed [15:0] px, logic signed [15:0] py,
                                 logic signed [14:0] hd);
    cmd_t c;
    longint dx, dy, reach, err, mag, ang, lin;
    c.linear_speed = '0;
    c.angular_rate = '0;
    c.drive_mode = MODE_ARRIVED;
    dx = longint'(tgt_x) - longint'(px);
    dy = longint'(tgt_y) - longint'(py);
    reach = int_sqrt(dx * dx + dy * dy);
    if (reach > longint'(r_arr)) begin
      err = bearing_q12(dy, dx) - longint'(hd);
      if (err > 12868) err = err - 25736;
      else if (err < -12868) err = err + 25736;
      mag = err < 0 ? -err : err;
      if (mag > longint'(tol)) begin
        c.drive_mode = MODE_TURN;
        ang = floor_shift(longint'(k_ang) * err, 12);
        if (ang > 32767) ang = 32767;
        if (ang < -32768) ang = -32768;
        c.angular_rate = ang[15:0];
      end else begin
        c.drive_mode = MODE_DRIVE;
        lin = (longint'(k_lin) * reach) >>> 8;
        if (lin > longint'(v_max)) lin = v_max;
        c.linear_speed = lin[15:0];
      end
    end
    return c;
  endfunction

  assign pending_o = cmd_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    cmd_t e;
    int n_err;
    if (!rst_ni) begin
      tgt_x <= 16'sd256; tgt_y <= 16'sd256;
      k_lin <= 12'd256; k_ang <= 12'd256;
      v_max <= 16'd768; r_arr <= 15'd26; tol <= 14'd819;
      errors_o <= 0;
      cmd_q.delete();
    end else begin
      n_err = 0;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_TARGET_X:  tgt_x <= cfg_data_i;
          REG_TARGET_Y:  tgt_y <= cfg_data_i;
          REG_GAIN_LIN:  k_lin <= cfg_data_i[11:0];
          REG_GAIN_ANG:  k_ang <= cfg_data_i[11:0];
          REG_SPEED_LIM: v_max <= cfg_data_i;
          REG_ARRIVE_R:  r_arr <= cfg_data_i[14:0];
          REG_HEAD_TOL:  tol <= cfg_data_i[13:0];
          default: ;
        endcase
      end
      if (pose_ch.valid && pose_ch.ready)
        cmd_q.push_back(steer(pose_ch.pos_x, pose_ch.pos_y, pose_ch.heading));
      if (cmd_ch.valid && cmd_ch.ready) begin
        if (cmd_q.size() == 0) begin
          $error("command beat with no pose pending");
          n_err = n_err + 1;
        end else begin
          e = cmd_q.pop_front();
          if (cmd_ch.linear_speed !== e.linear_speed) begin
            $error("linear_speed expected %0d actual %0d", e.linear_speed,
                   cmd_ch.linear_speed);
            n_err = n_err + 1;
          end
          if (cmd_ch.angular_rate !== e.angular_rate) begin
            $error("angular_rate expected %0d actual %0d", e.angular_rate,
                   cmd_ch.angular_rate);
            n_err = n_err + 1;
          end
          if (cmd_ch.drive_mode !== e.drive_mode) begin
            $error("drive_mode expected %0d actual %0d", e.drive_mode,
                   cmd_ch.drive_mode);
            n_err = n_err + 1;
          end
        end
      end
      errors_o <= errors_o + n_err;
    end
  end
endmodule
`default_nettype wire

// ===== tb/go_to_goal_steering_controller_tb.sv =====
// Testbench top: drives poses and register writes into the controller and gives the verdict.
`default_nettype none
module go_to_goal_steering_controller_tb;
  import gtg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps = 16;
  localparam int Latency = Steps + 24;
  localparam int Limit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  int errors, pending, cycles;
  bit hold_rx = 1'b0;
  bit quiet = 1'b0;
  logic [15:0] DUT_tx = 16'd256, DUT_ty = 16'd256;

  gtg_pose_if pose_ch();
  gtg_cmd_if  cmd_ch();

  always #2 clk_i = ~clk_i;

  go_to_goal_steering_controller #(.CORDIC_STEPS(Steps)) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .pose_ch(pose_ch.sink), .cmd_ch(cmd_ch.source)
  );

  gtg_checker #(.CORDIC_STEPS(Steps)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .pose_ch, .cmd_ch, .errors_o(errors), .pending_o(pending)
  );

  initial begin
    pose_ch.valid = 1'b0;
    pose_ch.pos_x = '0;
    pose_ch.pos_y = '0;
    pose_ch.heading = '0;
    cmd_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("go_to_goal_steering_controller: mismatch");
      $finish;
    end
  end

  // receiver: random stall bursts, long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        cmd_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        cmd_ch.ready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        cmd_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    pose_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  // offer one pose and hold it until accepted
  task automatic send_pose(logic [15:0] px, logic [15:0] py, logic [14:0] hd);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      pose_ch.valid <= 1'b0;
      n = $urandom_range(1, 6);
      repeat (n) @(negedge clk_i);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.pos_x <= px;
    pose_ch.pos_y <= py;
    pose_ch.heading <= hd;
    @(posedge clk_i);
    while (!pose_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic rand_pose(int near);
    logic [15:0] px, py;
    logic [14:0] hd;
    hd = 15'($urandom_range(0, 25736) - 12868);
    if ($urandom_range(0, 9) == 0) hd = 15'($urandom());
    if (near != 0) begin
      px = DUT_tx + 16'($urandom_range(0, 2 * near) - near);
      py = DUT_ty + 16'($urandom_range(0, 2 * near) - near);
    end else begin
      px = 16'($urandom());
      py = 16'($urandom());
    end
    send_pose(px, py, hd);
  endtask

  task automatic set_target(logic [15:0] tx, logic [15:0] ty);
    write_reg(REG_TARGET_X, tx);
    write_reg(REG_TARGET_Y, ty);
    DUT_tx = tx;
    DUT_ty = ty;
  endtask

  initial begin
    logic [15:0] ex[4];
    int sel;
    ex = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: defaults, extremes, exact target, heading out of range
    @(negedge clk_i);
    send_pose(16'd256, 16'd256, 15'd0);
    send_pose(16'd256, 16'd0, 15'd0);
    send_pose(16'd0, 16'd256, 15'd0);
    send_pose(16'd256, 16'd0, -15'sd6434);
    send_pose(16'd512, 16'd256, 15'd12868);
    send_pose(16'd512, 16'd256, -15'sd12868);
    send_pose(16'd512, 16'd200, 15'h3FFF);
    send_pose(16'd512, 16'd300, 15'h4000);
    send_pose(16'd0, 16'd0, 15'h7FFF);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_pose(ex[i], ex[j], 15'($urandom()));
    drain();
    // extreme registers, wide data bits and an unused index
    set_target(16'h8000, 16'h7FFF);
    write_reg(REG_GAIN_LIN, 16'hFFFF);
    write_reg(REG_GAIN_ANG, 16'hFFFF);
    write_reg(REG_SPEED_LIM, 16'hFFFF);
    write_reg(REG_ARRIVE_R, 16'hFFFF);
    write_reg(REG_HEAD_TOL, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h1234);
    for (int i = 0; i < 4; i++) send_pose(ex[i], ex[3 - i], 15'($urandom()));
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      sel = $urandom_range(0, 3);
      set_target(ph == 1 ? 16'h7FFF : 16'($urandom()),
                 ph == 1 ? 16'h8000 : 16'($urandom()));
      write_reg(REG_GAIN_LIN, ph == 2 ? 16'd0 : 16'($urandom()));
      write_reg(REG_GAIN_ANG, ph == 2 ? 16'd0 : 16'($urandom()));
      write_reg(REG_SPEED_LIM, ph == 3 ? 16'd0 : 16'($urandom()));
      write_reg(REG_ARRIVE_R, ph == 3 ? 16'd0 : 16'($urandom_range(0, 2000)));
      write_reg(REG_HEAD_TOL, ph == 4 ? 16'd0 : (ph == 5 ? 16'd12868 :
                16'($urandom_range(0, 16383))));
      if (ph == 7) quiet = 1'b1;
      for (int k = 0; k < 120; k++) begin
        if (ph == 2 && k == 10) begin
          fork
            begin
              hold_rx = 1'b1;
              repeat (Latency * 3) @(posedge clk_i);
              hold_rx = 1'b0;
            end
          join_none
        end
        case (sel)
          0: rand_pose(0);
          1: rand_pose(512);
          default: rand_pose(4000);
        endcase
      end
      drain();
    end
    if (errors == 0) begin
      $display("go_to_goal_steering_controller: match");
    end else begin
      $display("go_to_goal_steering_controller: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
